[hw/rtl/mup_pkg.sv]
// shared types and constants of the usart-style midi port
package mup_pkg;

   localparam int DATA_W = 8;

   // opcodes of an input item
   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_DRAIN = 2'd2;

   // port offsets inside the eight-port window
   localparam logic [7:0] OFS_DATA   = 8'd0;
   localparam logic [7:0] OFS_CMD    = 8'd1;
   localparam logic [7:0] PORT_COUNT = 8'd8;

   // command register bits
   localparam int CMD_TX_OFF_BIT = 6;
   localparam int CMD_TX_EN_BIT  = 0;

   // status register bits
   localparam int STAT_NOT_FULL_BIT = 0;
   localparam int STAT_RX_RDY_BIT   = 1;
   localparam int STAT_EMPTY_BIT    = 2;

   localparam logic [7:0] BUS_IDLE   = 8'hFF;
   localparam logic [7:0] TIMER_READ = 8'h00;
   localparam logic [7:0] BASE_RESET = 8'd232;

   typedef struct packed {
      logic [1:0]        opcode;
      logic [7:0]        port;
      logic [7:0]        write_data;
      logic              rx_ready;
      logic [7:0]        rx_byte;
   } req_type;

   typedef struct packed {
      logic [7:0]        read_data;
      logic              drive_bus;
      logic              rx_take;
      logic              tx_valid;
      logic [7:0]        tx_byte;
      logic              tx_dropped;
   } rsp_type;

   typedef struct packed {
      logic full;
      logic empty;
   } txq_status_type;

endpackage

[hw/rtl/mup_txq.sv]
// transmit fifo: byte memory with write and read pointers
module mup_txq #(
   parameter int DEPTH = 256
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  logic [mup_pkg::DATA_W-1:0] push_data,
   input  logic                    pop,
   output mup_pkg::txq_status_type status,
   output logic [mup_pkg::DATA_W-1:0] pop_data
);
   import mup_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0]  wr_next, rd_next;
   logic [DATA_W-1:0] pop_data_ff;

   // pointers count 0..DEPTH-1 and wrap, one entry stays free
   assign wr_next = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
   assign rd_next = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;

   assign status.full  = (wr_next == rd_ptr_ff);
   assign status.empty = (wr_ptr_ff == rd_ptr_ff);

   assign wr_ptr_in = push ? wr_next : wr_ptr_ff;
   assign rd_ptr_in = pop  ? rd_next : rd_ptr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
      if (pop) begin
         pop_data_ff <= mem[rd_ptr_ff];
      end
   end

   assign pop_data = pop_data_ff;

endmodule

[hw/rtl/midi_usart_port_with_tx_fifo.sv]
// Usart-style midi port with transmit fifo on an 8-bit i/o bus. It answers eight
// ports from csr port_base (data, command/status, six timer ports). Each req
// transfer is a bus write, a bus read or a drain request and yields exactly one
// rsp transfer. One item is taken per clock while rsp_stall does not hold the rsp
// output; a result is registered in the s1 stage, where the fifo read lands, then
// in the rsp output register. The fifo holds FIFO_DEPTH-1 bytes; its memory has no
// reset and needs no clearing pass. Write port_base only while the block is idle.
module midi_usart_port_with_tx_fifo #(
   parameter int FIFO_DEPTH = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  mup_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output mup_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [7:0]       csr_data
);
   import mup_pkg::*;

   logic           req_accept;
   logic           s1_advance;
   logic           s1_valid_ff;
   rsp_type        s1_rsp_ff, s1_rsp_in;
   rsp_type        s1_rsp_fill;
   logic           rsp_valid_ff;
   rsp_type        rsp_data_ff;
   logic [7:0]     port_base_ff;
   logic           tx_en_ff, tx_en_in;
   logic [7:0]     offset;
   logic           push, pop;
   txq_status_type q_status;
   logic [7:0]     pop_data;

   mup_txq #(.DEPTH(FIFO_DEPTH)) u_txq (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (req_data.write_data),
      .pop       (pop),
      .status    (q_status),
      .pop_data  (pop_data)
   );

   assign s1_advance = s1_valid_ff & (~rsp_valid_ff | ~rsp_stall);
   assign req_stall  = s1_valid_ff & ~s1_advance;
   assign req_accept = req_valid & ~req_stall;
   assign csr_ready  = 1'b1;
   assign offset     = req_data.port - port_base_ff;

   always_comb begin
      push      = 1'b0;
      pop       = 1'b0;
      tx_en_in  = tx_en_ff;
      s1_rsp_in = '0;
      if (req_accept) begin
         unique case (req_data.opcode)
            OP_WRITE: begin
               if (offset == OFS_DATA) begin
                  if (tx_en_ff) begin
                     if (q_status.full) begin
                        s1_rsp_in.tx_dropped = 1'b1;
                     end else begin
                        push = 1'b1;
                     end
                  end
               end else if (offset == OFS_CMD) begin
                  tx_en_in = ~req_data.write_data[CMD_TX_OFF_BIT]
                           & req_data.write_data[CMD_TX_EN_BIT];
               end
            end
            OP_READ: begin
               if (offset == OFS_DATA) begin
                  s1_rsp_in.drive_bus = 1'b1;
                  s1_rsp_in.rx_take   = req_data.rx_ready;
                  s1_rsp_in.read_data = req_data.rx_ready ? req_data.rx_byte : BUS_IDLE;
               end else if (offset == OFS_CMD) begin
                  s1_rsp_in.drive_bus                      = 1'b1;
                  s1_rsp_in.read_data[STAT_NOT_FULL_BIT]   = ~q_status.full;
                  s1_rsp_in.read_data[STAT_RX_RDY_BIT]     = req_data.rx_ready;
                  s1_rsp_in.read_data[STAT_EMPTY_BIT]      = q_status.empty;
               end else if (offset < PORT_COUNT) begin
                  s1_rsp_in.drive_bus = 1'b1;
                  s1_rsp_in.read_data = TIMER_READ;
               end else begin
                  s1_rsp_in.read_data = BUS_IDLE;
               end
            end
            OP_DRAIN: begin
               if (!q_status.empty) begin
                  pop                = 1'b1;
                  s1_rsp_in.tx_valid = 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   // popped byte arrives from memory in the cycle after the pop
   always_comb begin
      s1_rsp_fill         = s1_rsp_ff;
      s1_rsp_fill.tx_byte = s1_rsp_ff.tx_valid ? pop_data : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         tx_en_ff     <= 1'b0;
         port_base_ff <= BASE_RESET;
      end else begin
         s1_valid_ff <= req_accept | (s1_valid_ff & ~s1_advance);
         if (s1_advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         tx_en_ff <= tx_en_in;
         if (csr_valid && csr_ready) begin
            port_base_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_rsp_ff <= s1_rsp_in;
      end
      if (s1_advance) begin
         rsp_data_ff <= s1_rsp_fill;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[hw/rtl/mup_checker.sv]
// port-level checks of the midi port, bound to the top level
module mup_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input mup_pkg::rsp_type rsp_data
);
   import mup_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled rsp transfer changed");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

   a_drain_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.tx_valid |-> !rsp_data.drive_bus && !rsp_data.tx_dropped
                                         && !rsp_data.rx_take)
      else $error("popped byte mixed with bus result");

   a_tx_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.tx_valid |-> rsp_data.tx_byte == 8'h00)
      else $error("tx byte without pop");

   a_take_drives: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.rx_take |-> rsp_data.drive_bus)
      else $error("receive byte taken on undriven bus");

endmodule

bind midi_usart_port_with_tx_fifo mup_checker u_mup_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
